// ===== src/lsot_pkg.sv =====
// Shared types, widths and the control program of the trajectory generator.
// Used by the multiplier unit and the top level.
package lsot_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // datapath widths (fixed by the 32-bit fields and the 2^39 product cap)
  localparam int GW   = 32;          // gain register
  localparam int HALF = 16;          // gain split for the partial products
  localparam int XW   = 41;          // signed multiplier operand
  localparam int PMW  = 40;          // product magnitude, capped at 2^39
  localparam int AW   = 42;          // signed accumulator
  localparam int PW   = XW + HALF;   // one partial product
  localparam int FW   = PW + HALF + 1;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [CFG_IW-1:0] {
    REG_GAIN_POS  = 3'd0,
    REG_GAIN_VEL  = 3'd1,
    REG_ACCEL_LIM = 3'd2,
    REG_VEL_LIM   = 3'd3,
    REG_STEP_TIME = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET_CMD = 2'd1,
    REQ_FORCE   = 2'd2,
    REQ_ABORT   = 2'd3
  } req_t;

  // multiplier unit micro-ops
  typedef enum logic [2:0] {
    MOP_NONE, MOP_LOAD, MOP_HI, MOP_LO, MOP_FIN
  } mop_t;

  typedef enum logic [1:0] {
    G_KP, G_KV, G_DT
  } gsel_t;

  // operand register updates
  typedef enum logic [2:0] {
    XOP_NONE, XOP_ERR, XOP_VEL, XOP_CLAMP_A, XOP_CLAMP_V, XOP_CMD_DPOS, XOP_SUB_NPOS
  } xop_t;

  // accumulator updates
  typedef enum logic [2:0] {
    AOP_NONE, AOP_SETP, AOP_SUBP, AOP_VADDP, AOP_PADDP
  } aop_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_ALWAYS, JMP_IF_PASS, JMP_DONE
  } jmp_t;

  localparam int PROG_LEN = 25;
  localparam int PCW      = $clog2(PROG_LEN);

  localparam logic [PCW-1:0] STEP_GAIN_LOOP = PCW'(1);
  localparam logic [PCW-1:0] STEP_OUT       = PCW'(24);

  typedef struct packed {
    mop_t           mop;
    gsel_t          gsel;
    xop_t           xop;
    aop_t           aop;
    logic           wr_nvel;
    logic           wr_dpos;
    logic           wr_npos;
    logic           set_pass;
    jmp_t           jmp;
    logic [PCW-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic           neg;
    logic [PMW-1:0] mag;
  } mul_res_t;

  // Steps 1..9 form k1*x - k2*v; run once for the acceleration and once
  // (pass set) for the corrected acceleration.
  localparam ctl_word_t PROGRAM [PROG_LEN] = '{
    '{MOP_NONE, G_KP, XOP_ERR,      AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LOAD, G_KP, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_HI,   G_KP, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LO,   G_KP, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_FIN,  G_KP, XOP_VEL,      AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LOAD, G_KV, XOP_NONE,     AOP_SETP,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_HI,   G_KV, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LO,   G_KV, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_FIN,  G_KV, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_NONE, G_KV, XOP_NONE,     AOP_SUBP,  1'b0, 1'b0, 1'b0, 1'b0, JMP_IF_PASS,
      STEP_OUT},
    '{MOP_NONE, G_DT, XOP_CLAMP_A,  AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LOAD, G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_HI,   G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LO,   G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_FIN,  G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_NONE, G_DT, XOP_NONE,     AOP_VADDP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_NONE, G_DT, XOP_CLAMP_V,  AOP_NONE,  1'b1, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LOAD, G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_HI,   G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_LO,   G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_FIN,  G_DT, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_NONE, G_DT, XOP_NONE,     AOP_PADDP, 1'b0, 1'b1, 1'b0, 1'b0, JMP_NEXT,    '0},
    '{MOP_NONE, G_DT, XOP_CMD_DPOS, AOP_NONE,  1'b0, 1'b0, 1'b1, 1'b0, JMP_NEXT,    '0},
    '{MOP_NONE, G_KP, XOP_SUB_NPOS, AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b1, JMP_ALWAYS,
      STEP_GAIN_LOOP},
    '{MOP_NONE, G_KP, XOP_NONE,     AOP_NONE,  1'b0, 1'b0, 1'b0, 1'b0, JMP_DONE,    '0}
  };

endpackage

// ===== src/lsot_in_if.sv =====
// Request channel: valid/ready handshake with request type and target value.
// Depends on nothing.
interface lsot_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] target_value;

  modport source (output valid, req_type, target_value, input ready);
  modport sink (input valid, req_type, target_value, output ready);
endinterface

// ===== src/lsot_out_if.sv =====
// Result channel: valid/ready handshake with planned position, velocity, accel.
// Depends on nothing.
interface lsot_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] plan_position;
  logic signed [31:0] plan_velocity;
  logic signed [31:0] plan_accel;

  modport source (output valid, plan_position, plan_velocity, plan_accel, input ready);
  modport sink (input valid, plan_position, plan_velocity, plan_accel, output ready);
endinterface

// ===== src/lsot_mul.sv =====
// Shared saturating Q multiplier: gain (unsigned 32) times signed operand,
// one 41x16 partial product per step. Depends on lsot_pkg.
module lsot_mul #(
  parameter int FRAC_BITS = lsot_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  lsot_pkg::mop_t                   op,
  input  logic signed [lsot_pkg::XW-1:0]   x,
  input  logic [lsot_pkg::GW-1:0]          gain,
  output lsot_pkg::mul_res_t               res
);

  localparam int XW   = lsot_pkg::XW;
  localparam int PW   = lsot_pkg::PW;
  localparam int FW   = lsot_pkg::FW;
  localparam int PMW  = lsot_pkg::PMW;
  localparam int GW   = lsot_pkg::GW;
  localparam int HALF = lsot_pkg::HALF;

  // upper partial product this large already means a capped result
  localparam logic [PW-1:0] HI_CAP = PW'(1) << (23 + FRAC_BITS);
  localparam logic [FW-1:0] Q_CAP  = FW'(1) << (PMW - 1);

  logic [XW-1:0]  mag_r;
  logic           neg_r;
  logic [GW-1:0]  gain_r;
  logic [PW-1:0]  ph_r;
  logic [PW-1:0]  pl_r;
  logic [PMW-1:0] pm_r;
  logic           pneg_r;

  logic [FW-1:0]  full;
  logic [FW-1:0]  quo;
  logic [PMW-1:0] fin_mag;

  always_comb begin
    full    = FW'({ph_r, {HALF{1'b0}}}) + FW'(pl_r);
    quo     = full >> FRAC_BITS;
    fin_mag = (ph_r >= HI_CAP || quo > Q_CAP) ? PMW'(Q_CAP) : PMW'(quo);
  end

  always_ff @(posedge clk) begin
    unique case (op)
      lsot_pkg::MOP_LOAD: begin
        mag_r  <= x[XW-1] ? XW'(-x) : XW'(x);
        neg_r  <= x[XW-1];
        gain_r <= gain;
      end
      lsot_pkg::MOP_HI: ph_r <= PW'(mag_r) * PW'(gain_r[GW-1:HALF]);
      lsot_pkg::MOP_LO: pl_r <= PW'(mag_r) * PW'(gain_r[HALF-1:0]);
      lsot_pkg::MOP_FIN: begin
        pm_r   <= fin_mag;
        pneg_r <= neg_r;
      end
      lsot_pkg::MOP_NONE: ;
      default: ;
    endcase
  end

  assign res = '{neg: pneg_r, mag: pm_r};

endmodule

// ===== src/limited_second_order_trajectory_top.sv =====
// Top level of the rate-limited second-order trajectory generator: config
// registers, microcoded sequencer and datapath. Depends on lsot_pkg,
// lsot_in_if, lsot_out_if and lsot_mul.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  in_ch    | in  | valid/ready        | req_type[1:0], target_value[31:0] signed
//  out_ch   | out | valid/ready        | plan_position, plan_velocity, plan_accel
//  cfg_*    | in  | cfg_wr_en, no wait | cfg_index[2:0], cfg_wdata[31:0]
//
// A tick runs a 34-step microprogram (six products on one shared 41x16
// multiplier, two partial products each); no new request is taken until
// the tick is done. Set, force and abort requests complete in their accept cycle.
// Reset is synchronous; nothing to sweep after it.
// A tick that finishes while the previous result is still unread waits on
// its last step and takes no request; when idle, requests are taken while a result waits.
module limited_second_order_trajectory_top #(
  parameter int FRAC_BITS = lsot_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lsot_in_if.sink                       in_ch,
  lsot_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [lsot_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [lsot_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int XW  = lsot_pkg::XW;
  localparam int AW  = lsot_pkg::AW;
  localparam int GW  = lsot_pkg::GW;
  localparam int PCW = lsot_pkg::PCW;

  localparam logic [GW-1:0] GAIN_RST = GW'(64'd1 << FRAC_BITS);
  localparam logic [30:0]   LIM_RST  = 31'(64'd1 << FRAC_BITS);
  localparam logic [16:0]   DT_RST   = 17'((64'd1311 << FRAC_BITS) >> 16);

  localparam logic signed [AW-1:0] S32_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] S32_MIN = -AW'(64'sd2147483648);

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    if (v > S32_MAX) begin
      return 32'(S32_MAX);
    end else if (v < S32_MIN) begin
      return 32'(S32_MIN);
    end
    return 32'(v);
  endfunction

  // config registers
  logic [GW-1:0] kp_r, kv_r;
  logic [30:0]   al_r, vl_r;
  logic [16:0]   dt_r;

  // trajectory state
  logic signed [31:0] cmd_r, pos_r, vel_r;

  // sequencer
  logic           busy_r, busy_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  logic           pass_r, pass_nxt;
  lsot_pkg::ctl_word_t cw;

  // scratch
  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [31:0]   nvel_r, npos_r;
  logic signed [XW-1:0] dpos_r;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_pos_r, out_vel_r, out_acc_r;

  logic               in_fire, out_stall, done_step;
  logic [GW-1:0]      gain_sel;
  lsot_pkg::mul_res_t mres;
  logic signed [XW-1:0] prod_mag, prod_s;
  logic signed [AW-1:0] lim_w, acc_clamp;

  assign cw        = lsot_pkg::PROGRAM[pc_r];
  assign in_fire   = in_ch.valid && !busy_r;
  assign out_stall = out_valid_r && !out_ch.ready;
  assign done_step = busy_r && (cw.jmp == lsot_pkg::JMP_DONE) && !out_stall;

  assign in_ch.ready          = !busy_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.plan_position = out_pos_r;
  assign out_ch.plan_velocity = out_vel_r;
  assign out_ch.plan_accel    = out_acc_r;

  always_comb begin
    unique case (cw.gsel)
      lsot_pkg::G_KP: gain_sel = kp_r;
      lsot_pkg::G_KV: gain_sel = kv_r;
      lsot_pkg::G_DT: gain_sel = GW'(dt_r);
      default:        gain_sel = '0;
    endcase
  end

  lsot_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .op   (busy_r ? cw.mop : lsot_pkg::MOP_NONE),
    .x    (x_r),
    .gain (gain_sel),
    .res  (mres)
  );

  assign prod_mag = signed'(XW'(mres.mag));
  assign prod_s   = mres.neg ? -prod_mag : prod_mag;

  // symmetric clamp, velocity limit on the velocity step
  always_comb begin
    lim_w = (cw.xop == lsot_pkg::XOP_CLAMP_V) ? AW'(signed'({1'b0, vl_r}))
                                               : AW'(signed'({1'b0, al_r}));
    if (acc_r > lim_w) begin
      acc_clamp = lim_w;
    end else if (acc_r < -lim_w) begin
      acc_clamp = -lim_w;
    end else begin
      acc_clamp = acc_r;
    end
  end

  // sequencer next state
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    pass_nxt = pass_r;
    if (!busy_r) begin
      if (in_fire && in_ch.req_type == lsot_pkg::REQ_TICK) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
        pass_nxt = 1'b0;
      end
    end else begin
      if (cw.set_pass) begin
        pass_nxt = 1'b1;
      end
      unique case (cw.jmp)
        lsot_pkg::JMP_NEXT:    pc_nxt = pc_r + 1'b1;
        lsot_pkg::JMP_ALWAYS:  pc_nxt = cw.target;
        lsot_pkg::JMP_IF_PASS: pc_nxt = pass_r ? cw.target : pc_r + 1'b1;
        lsot_pkg::JMP_DONE: begin
          if (!out_stall) begin
            busy_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // datapath next values
  always_comb begin
    x_nxt = x_r;
    case (cw.xop)
      lsot_pkg::XOP_ERR:      x_nxt = XW'(cmd_r) - XW'(pos_r);
      lsot_pkg::XOP_VEL:      x_nxt = pass_r ? XW'(nvel_r) : XW'(vel_r);
      lsot_pkg::XOP_CLAMP_A,
      lsot_pkg::XOP_CLAMP_V:  x_nxt = XW'(acc_clamp);
      lsot_pkg::XOP_CMD_DPOS: x_nxt = XW'(cmd_r) - dpos_r;
      lsot_pkg::XOP_SUB_NPOS: x_nxt = x_r - XW'(npos_r);
      default:                x_nxt = x_r;
    endcase

    acc_nxt = acc_r;
    case (cw.aop)
      lsot_pkg::AOP_SETP:  acc_nxt = AW'(prod_s);
      lsot_pkg::AOP_SUBP:  acc_nxt = acc_r - AW'(prod_s);
      lsot_pkg::AOP_VADDP: acc_nxt = AW'(vel_r) + AW'(prod_s);
      lsot_pkg::AOP_PADDP: acc_nxt = AW'(pos_r) + AW'(prod_s);
      default:             acc_nxt = acc_r;
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done_step) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r       <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
      kp_r        <= GAIN_RST;
      kv_r        <= GAIN_RST;
      al_r        <= LIM_RST;
      vl_r        <= LIM_RST;
      dt_r        <= DT_RST;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          lsot_pkg::REG_GAIN_POS:  kp_r <= cfg_wdata;
          lsot_pkg::REG_GAIN_VEL:  kv_r <= cfg_wdata;
          lsot_pkg::REG_ACCEL_LIM: al_r <= cfg_wdata[30:0];
          lsot_pkg::REG_VEL_LIM:   vl_r <= cfg_wdata[30:0];
          lsot_pkg::REG_STEP_TIME: dt_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        case (in_ch.req_type)
          lsot_pkg::REQ_SET_CMD: cmd_r <= in_ch.target_value;
          lsot_pkg::REQ_FORCE: begin
            cmd_r <= in_ch.target_value;
            pos_r <= in_ch.target_value;
            vel_r <= '0;
          end
          lsot_pkg::REQ_ABORT: begin
            cmd_r <= '0;
            pos_r <= '0;
            vel_r <= '0;
          end
          default: ;
        endcase
      end

      if (done_step) begin
        pos_r <= npos_r;
        vel_r <= nvel_r;
      end
    end
  end

  // scratch and result payload
  always_ff @(posedge clk) begin
    if (busy_r) begin
      x_r   <= x_nxt;
      acc_r <= acc_nxt;
      if (cw.wr_nvel) begin
        nvel_r <= 32'(acc_clamp);
      end
      if (cw.wr_dpos) begin
        dpos_r <= prod_s;
      end
      if (cw.wr_npos) begin
        npos_r <= sat32(acc_r);
      end
    end
    if (done_step) begin
      out_pos_r <= npos_r;
      out_vel_r <= nvel_r;
      out_acc_r <= sat32(acc_r);
    end
  end

endmodule
